// ===== design/emg_window_mav_centroid_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// EMG classifier assertion macros
// Shared property shorthands for the checker. All of them sample on the
// rising edge of clk and are switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef EMG_WINDOW_MAV_CENTROID_CLASSIFIER_ASSERT_SVH
`define EMG_WINDOW_MAV_CENTROID_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define EMGC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define EMGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/emgc_pkg.sv =====
// ----------------------------------------------------------------------------
// EMG classifier package
// Widths, register map, request and event codes, and the shared types of the
// window mean-absolute-value centroid classifier.
// ----------------------------------------------------------------------------
package emgc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 10;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int CNT1_W      = COUNT_BITS + 1;

  localparam int FIELD_W  = 12;
  localparam int WLEN_W   = 10;
  localparam int LOCK_W   = 16;
  localparam int MEAN_W   = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int WCMP_W   = (CNT1_W > WLEN_W) ? CNT1_W : WLEN_W;
  localparam int DIV_STEP_W = $clog2(SAMPLE_BITS);

  localparam logic [CNT1_W-1:0] COUNT_MAX = CNT1_W'((1 << COUNT_BITS) - 1);

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REJECT_DISTANCE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_MS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTROID_A      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTROID_B      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTROID_C      = 3'd5;

  localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH   = 10'd330;
  localparam logic [FIELD_W-1:0] RST_REJECT_DISTANCE = 12'd150;
  localparam logic [LOCK_W-1:0]  RST_LOCKOUT_MS      = 16'd500;
  localparam logic [FIELD_W-1:0] RST_CENTROID_A      = 12'd509;
  localparam logic [FIELD_W-1:0] RST_CENTROID_B      = 12'd680;
  localparam logic [FIELD_W-1:0] RST_CENTROID_C      = 12'd924;

  // Request codes
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_PRESS  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Class indexes
  localparam logic [1:0] CLASS_A = 2'd0;
  localparam logic [1:0] CLASS_B = 2'd1;
  localparam logic [1:0] CLASS_C = 2'd2;

  typedef enum logic [1:0] {
    EV_START      = 2'd0,
    EV_CLASSIFIED = 2'd1,
    EV_REJECT     = 2'd2
  } event_t;

  typedef struct packed {
    logic [WLEN_W-1:0]  window_length;
    logic [FIELD_W-1:0] reject_distance;
    logic [LOCK_W-1:0]  lockout_ms;
    logic [FIELD_W-1:0] centroid_a;
    logic [FIELD_W-1:0] centroid_b;
    logic [FIELD_W-1:0] centroid_c;
  } cfg_t;

  typedef struct packed {
    event_t             event_kind;
    logic [1:0]         gesture_class;
    logic [FIELD_W-1:0] mean_level;
    logic [FIELD_W-1:0] class_distance;
  } result_t;

endpackage

// ===== design/emgc_regs.sv =====
// ----------------------------------------------------------------------------
// EMG classifier configuration registers
// APB-style register file holding window length, reject limit, lockout time
// and the three class centroids.
// ----------------------------------------------------------------------------
module emgc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [emgc_pkg::PADDR_W-1:0]  paddr,
  input  logic [emgc_pkg::PDATA_W-1:0]  pwdata,
  output logic [emgc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output emgc_pkg::cfg_t                cfg
);

  logic [emgc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[emgc_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length   <= emgc_pkg::RST_WINDOW_LENGTH;
      cfg.reject_distance <= emgc_pkg::RST_REJECT_DISTANCE;
      cfg.lockout_ms      <= emgc_pkg::RST_LOCKOUT_MS;
      cfg.centroid_a      <= emgc_pkg::RST_CENTROID_A;
      cfg.centroid_b      <= emgc_pkg::RST_CENTROID_B;
      cfg.centroid_c      <= emgc_pkg::RST_CENTROID_C;
    end else if (wr_en) begin
      unique case (reg_idx)
        emgc_pkg::REG_WINDOW_LENGTH:
          cfg.window_length <= pwdata[emgc_pkg::WLEN_W-1:0];
        emgc_pkg::REG_REJECT_DISTANCE:
          cfg.reject_distance <= pwdata[emgc_pkg::FIELD_W-1:0];
        emgc_pkg::REG_LOCKOUT_MS:
          cfg.lockout_ms <= pwdata[emgc_pkg::LOCK_W-1:0];
        emgc_pkg::REG_CENTROID_A:
          cfg.centroid_a <= pwdata[emgc_pkg::FIELD_W-1:0];
        emgc_pkg::REG_CENTROID_B:
          cfg.centroid_b <= pwdata[emgc_pkg::FIELD_W-1:0];
        emgc_pkg::REG_CENTROID_C:
          cfg.centroid_c <= pwdata[emgc_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      emgc_pkg::REG_WINDOW_LENGTH:   prdata = emgc_pkg::PDATA_W'(cfg.window_length);
      emgc_pkg::REG_REJECT_DISTANCE: prdata = emgc_pkg::PDATA_W'(cfg.reject_distance);
      emgc_pkg::REG_LOCKOUT_MS:      prdata = emgc_pkg::PDATA_W'(cfg.lockout_ms);
      emgc_pkg::REG_CENTROID_A:      prdata = emgc_pkg::PDATA_W'(cfg.centroid_a);
      emgc_pkg::REG_CENTROID_B:      prdata = emgc_pkg::PDATA_W'(cfg.centroid_b);
      emgc_pkg::REG_CENTROID_C:      prdata = emgc_pkg::PDATA_W'(cfg.centroid_c);
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== design/emgc_div.sv =====
// ----------------------------------------------------------------------------
// EMG classifier window divider
// Restoring divider, one quotient bit per cycle, producing the floor mean of
// a capture window from its sum and sample count.
// ----------------------------------------------------------------------------
module emgc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [emgc_pkg::SUM_BITS-1:0]     dividend,
  input  logic [emgc_pkg::COUNT_BITS-1:0]   divisor,
  output logic                              done,
  output logic [emgc_pkg::SAMPLE_BITS-1:0]  quotient
);

  logic                                busy;
  logic [emgc_pkg::DIV_STEP_W-1:0]     step;
  logic [emgc_pkg::COUNT_BITS-1:0]     rem;
  logic [emgc_pkg::COUNT_BITS-1:0]     div_r;
  logic [emgc_pkg::COUNT_BITS:0]       trial;
  logic [emgc_pkg::COUNT_BITS+1:0]     diff;
  logic                                borrow;
  logic [emgc_pkg::COUNT_BITS-1:0]     rem_next;

  // The mean never exceeds the largest sample, so the upper part of the sum
  // is already below the divisor and only SAMPLE_BITS quotient bits remain.
  always_comb begin
    trial    = {rem, quotient[emgc_pkg::SAMPLE_BITS-1]};
    diff     = {1'b0, trial} - {2'b00, div_r};
    borrow   = diff[emgc_pkg::COUNT_BITS+1];
    rem_next = borrow ? trial[emgc_pkg::COUNT_BITS-1:0]
                      : diff[emgc_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= emgc_pkg::DIV_STEP_W'(emgc_pkg::SAMPLE_BITS - 1);
        rem      <= dividend[emgc_pkg::SUM_BITS-1:emgc_pkg::SAMPLE_BITS];
        quotient <= dividend[emgc_pkg::SAMPLE_BITS-1:0];
        div_r    <= divisor;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= {quotient[emgc_pkg::SAMPLE_BITS-2:0], ~borrow};
        step     <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/emgc_match.sv =====
// ----------------------------------------------------------------------------
// EMG classifier centroid matcher
// Walks the three centroids with one absolute-difference unit, keeps the
// nearest one (lower index on ties) and checks it against the reject limit.
// ----------------------------------------------------------------------------
module emgc_match (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [emgc_pkg::SAMPLE_BITS-1:0]  mean,
  input  emgc_pkg::cfg_t                    cfg,
  output logic                              done,
  output emgc_pkg::result_t                 res
);

  logic                            busy;
  logic [1:0]                      step;
  logic [emgc_pkg::MEAN_W-1:0]     mean_r;
  logic [emgc_pkg::MEAN_W-1:0]     near_gap;
  logic [1:0]                      best_idx;
  logic [emgc_pkg::FIELD_W-1:0]    centroid;
  logic [emgc_pkg::MEAN_W-1:0]     cent_ext;
  logic [emgc_pkg::MEAN_W-1:0]     step_gap;

  always_comb begin
    unique case (step)
      emgc_pkg::CLASS_A: centroid = cfg.centroid_a;
      emgc_pkg::CLASS_B: centroid = cfg.centroid_b;
      emgc_pkg::CLASS_C: centroid = cfg.centroid_c;
      default:           centroid = cfg.centroid_a;
    endcase
    cent_ext = emgc_pkg::MEAN_W'(centroid);
    step_gap = (mean_r > cent_ext) ? (mean_r - cent_ext) : (cent_ext - mean_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= emgc_pkg::CLASS_A;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        step   <= emgc_pkg::CLASS_A;
        mean_r <= emgc_pkg::MEAN_W'(mean);
      end else if (busy) begin
        // A strictly smaller distance is needed to move off a lower index.
        if (step == emgc_pkg::CLASS_A || step_gap < near_gap) begin
          near_gap <= step_gap;
          best_idx <= step;
        end
        step <= step + 1'b1;
        if (step == emgc_pkg::CLASS_C) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.event_kind     = (near_gap > emgc_pkg::MEAN_W'(cfg.reject_distance))
                         ? emgc_pkg::EV_REJECT : emgc_pkg::EV_CLASSIFIED;
    res.gesture_class  = best_idx;
    res.mean_level     = emgc_pkg::FIELD_W'(mean_r);
    res.class_distance = emgc_pkg::FIELD_W'(near_gap);
  end

endmodule

// ===== design/emg_window_mav_centroid_classifier.sv =====
// ----------------------------------------------------------------------------
// EMG window mean-absolute-value centroid classifier
// Button-triggered capture of a sample window, floor mean, and nearest of
// three centroids with a reject limit.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, req_type, sample_value) takes
// one transaction per sample, button press or millisecond tick. The output
// channel (out_valid, out_stall and the four result fields) carries a start
// event for each accepted press that opens a capture, and one classified or
// rejected event when a window fills. Configuration is to be written through
// the APB port only while the block is idle; the block itself does not
// enforce this.
// Ticks, ignored items and window samples other than the last keep the block
// idle, so such items can follow back to back. A press that starts a capture
// puts its event into the pending register, from which S_EMIT moves it into
// the output register once that is free. The last sample of a window runs the
// serial divider (one quotient bit per cycle), then the centroid matcher, then
// S_EMIT for its result. in_stall is high from acceptance until S_EMIT ends.
// When the receiver holds out_stall, the result waits in the output register
// and the block keeps taking items until it has a new result to hand over.
// Reset clears out_valid, the capture state and the lockout timer, and loads
// the register reset values.
// ----------------------------------------------------------------------------
module emg_window_mav_centroid_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [emgc_pkg::SAMPLE_BITS-1:0]  sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        event_kind,
  output logic [1:0]                        gesture_class,
  output logic [emgc_pkg::FIELD_W-1:0]      mean_level,
  output logic [emgc_pkg::FIELD_W-1:0]      class_distance,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [emgc_pkg::PADDR_W-1:0]      paddr,
  input  logic [emgc_pkg::PDATA_W-1:0]      pwdata,
  output logic [emgc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MATCH,
    S_EMIT
  } state_t;

  state_t                             state;
  emgc_pkg::cfg_t                     cfg;
  emgc_pkg::result_t                  pend;
  emgc_pkg::result_t                  out_res;
  emgc_pkg::result_t                  match_res;

  logic [emgc_pkg::SUM_BITS-1:0]      window_sum;
  logic [emgc_pkg::COUNT_BITS-1:0]    window_count;
  logic                               capture_active;
  logic [emgc_pkg::LOCK_W-1:0]        press_elapsed;

  logic                               div_start;
  logic                               div_done;
  logic [emgc_pkg::SAMPLE_BITS-1:0]   div_quotient;
  logic                               match_start;
  logic                               match_done;

  logic                               accept;
  logic                               lock_done;
  logic [emgc_pkg::SUM_BITS-1:0]      sum_next;
  logic [emgc_pkg::CNT1_W-1:0]        cnt_next;
  logic                               win_end;

  emgc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  emgc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .divisor  (window_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  emgc_match u_match (
    .clk   (clk),
    .rst   (rst),
    .start (match_start),
    .mean  (div_quotient),
    .cfg   (cfg),
    .done  (match_done),
    .res   (match_res)
  );

  assign in_stall       = (state != S_IDLE);
  assign event_kind     = out_res.event_kind;
  assign gesture_class  = out_res.gesture_class;
  assign mean_level     = out_res.mean_level;
  assign class_distance = out_res.class_distance;

  always_comb begin
    accept    = in_valid && !in_stall;
    lock_done = (press_elapsed >= cfg.lockout_ms);
    sum_next  = window_sum + emgc_pkg::SUM_BITS'(sample_value);
    cnt_next  = {1'b0, window_count} + 1'b1;
    // The window also closes when the count reaches the largest value its register holds.
    win_end   = (emgc_pkg::WCMP_W'(cnt_next) >= emgc_pkg::WCMP_W'(cfg.window_length))
                || (cnt_next >= emgc_pkg::COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      window_sum     <= '0;
      window_count   <= '0;
      capture_active <= 1'b0;
      press_elapsed  <= '0;
      div_start      <= 1'b0;
      match_start    <= 1'b0;
    end else begin
      div_start   <= 1'b0;
      match_start <= 1'b0;
      // In S_EMIT the output register is loaded below instead.
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              emgc_pkg::REQ_TICK: begin
                if (!lock_done) begin
                  press_elapsed <= press_elapsed + 1'b1;
                end
              end
              emgc_pkg::REQ_PRESS: begin
                if (lock_done) begin
                  press_elapsed <= '0;
                  if (!capture_active) begin
                    window_sum          <= '0;
                    window_count        <= '0;
                    capture_active      <= 1'b1;
                    pend.event_kind     <= emgc_pkg::EV_START;
                    pend.gesture_class  <= emgc_pkg::CLASS_A;
                    pend.mean_level     <= '0;
                    pend.class_distance <= '0;
                    state               <= S_EMIT;
                  end
                end
              end
              emgc_pkg::REQ_SAMPLE: begin
                if (capture_active) begin
                  window_sum   <= sum_next;
                  window_count <= cnt_next[emgc_pkg::COUNT_BITS-1:0];
                  if (win_end) begin
                    capture_active <= 1'b0;
                    div_start      <= 1'b1;
                    state          <= S_DIV;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            match_start <= 1'b1;
            state       <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (match_done) begin
            pend  <= match_res;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_res   <= pend;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/emgc_checker.sv =====
// ----------------------------------------------------------------------------
// EMG classifier port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "emg_window_mav_centroid_classifier_assert.svh"

module emgc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        req_type,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        event_kind,
  input logic [1:0]                        gesture_class,
  input logic [emgc_pkg::FIELD_W-1:0]      mean_level,
  input logic [emgc_pkg::FIELD_W-1:0]      class_distance
);

  // A stalled result transaction keeps its payload.
  `EMGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(gesture_class) && $stable(mean_level) && $stable(class_distance))

  // Start events carry no class, mean or distance.
  `EMGC_ASSERT_IMP(a_start_zero, out_valid && event_kind == emgc_pkg::EV_START, gesture_class == emgc_pkg::CLASS_A && mean_level == '0 && class_distance == '0)

  // Nothing is offered right after reset.
  `EMGC_ASSERT_IMP(a_reset_clear, $past(rst), !out_valid)

  // A tick accepted in idle leaves the block ready for the next item.
  `EMGC_ASSERT_NEXT(a_tick_ready, in_valid && !in_stall && req_type == emgc_pkg::REQ_TICK, !in_stall)

endmodule

bind emg_window_mav_centroid_classifier emgc_checker u_emgc_checker (.*);
